// ----- rtl/core/trhq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Touch report hold qualifier package
// Shared widths, register indexes and beat types of the qualifier.
// ----------------------------------------------------------------------------
package trhq_pkg;

	localparam int RAW_LANES  = 5;
	localparam int RAW_W      = 11;
	localparam int PT_W       = 12;
	localparam int THR_W      = 8;
	localparam int HOLD_W     = 4;
	localparam int DIM_W      = 11;
	localparam int CNT_IN_W   = 4;
	localparam int CNT_OUT_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [THR_W-1:0]  JITTER_RESET = 8'd5;
	localparam logic [HOLD_W-1:0] HOLD_RESET   = 4'd10;
	localparam logic [DIM_W-1:0]  WIDTH_RESET  = 11'd800;
	localparam logic [DIM_W-1:0]  HEIGHT_RESET = 11'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JITTER = 2'd0,
		REG_HOLD   = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} cfg_reg_e;

	typedef struct packed {
		logic                          has_report;
		logic [CNT_IN_W-1:0]           raw_count;
		logic [RAW_LANES*RAW_W-1:0]    raw_x_packed;
		logic [RAW_LANES*RAW_W-1:0]    raw_y_packed;
		logic                          keyer_desktop;
	} tick_t;

	typedef struct packed {
		logic                          event_created;
		logic                          event_pending;
		logic                          same_spot_hold;
		logic [CNT_OUT_W-1:0]          point_count;
		logic [RAW_LANES*PT_W-1:0]     points_x_packed;
		logic [RAW_LANES*PT_W-1:0]     points_y_packed;
	} result_t;

	typedef struct packed {
		logic load_cur;
		logic load_lat;
	} lane_ctrl_t;

	typedef struct packed {
		logic created;
		logic pending;
		logic held;
	} status_t;

endpackage
`default_nettype wire

// ----- rtl/core/trhq_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Touch point lane
// Mirrors one raw point, keeps its current and latched copies and flags a move.
// ----------------------------------------------------------------------------
module trhq_lane
	import trhq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [RAW_W-1:0]  raw_x,
	input  wire logic [RAW_W-1:0]  raw_y,
	input  wire logic              active,
	input  wire logic [DIM_W-1:0]  screen_width,
	input  wire logic [DIM_W-1:0]  screen_height,
	input  wire logic [THR_W-1:0]  jitter_threshold,
	input  wire lane_ctrl_t        ctrl,
	output logic [PT_W-1:0]        next_x,
	output logic [PT_W-1:0]        next_y,
	output logic                   moved
);

	logic [PT_W-1:0] cur_x_q, cur_y_q;
	logic [PT_W-1:0] lat_x_q, lat_y_q;
	logic [PT_W-1:0] new_x, new_y;
	logic [PT_W:0]   dx, dy, ax, ay;

	assign new_x = active ? ({1'b0, screen_width} - {1'b0, raw_x}) : '0;
	assign new_y = active ? ({1'b0, screen_height} - {1'b0, raw_y}) : '0;

	assign dx = {lat_x_q[PT_W-1], lat_x_q} - {new_x[PT_W-1], new_x};
	assign dy = {lat_y_q[PT_W-1], lat_y_q} - {new_y[PT_W-1], new_y};
	assign ax = dx[PT_W] ? (~dx + (PT_W+1)'(1)) : dx;
	assign ay = dy[PT_W] ? (~dy + (PT_W+1)'(1)) : dy;

	assign moved = active && ((ax > (PT_W+1)'(jitter_threshold)) ||
		(ay > (PT_W+1)'(jitter_threshold)));

	assign next_x = ctrl.load_cur ? new_x : cur_x_q;
	assign next_y = ctrl.load_cur ? new_y : cur_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else if (ctrl.load_cur) begin
			cur_x_q <= new_x;
			cur_y_q <= new_y;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_lat) begin
			lat_x_q <= new_x;
			lat_y_q <= new_y;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/trhq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Touch event control
// Merges the lane move flags and runs the pending flag and hold counter.
// ----------------------------------------------------------------------------
module trhq_ctrl
	import trhq_pkg::*;
#(
	parameter int N  = 5,
	parameter int CW = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic              has_report,
	input  wire logic              keyer_desktop,
	input  wire logic [CW-1:0]     count,
	input  wire logic [HOLD_W-1:0] hold_ticks,
	input  wire logic [N-1:0]      moved,
	output lane_ctrl_t             lane_ctrl,
	output status_t                status,
	output logic [CW-1:0]          count_next
);

	logic              pending_q, pending_d;
	logic [HOLD_W-1:0] hold_cnt_q, hold_cnt_d;
	logic [CW-1:0]     cur_count_q;
	logic [CW-1:0]     lat_count_q;
	logic              report_nz, run, held, created;

	assign report_nz = has_report && (count != '0);
	assign run       = !(has_report && (count == '0));
	assign held      = pending_q && report_nz && (lat_count_q == count) && !(|moved);
	assign created   = report_nz && !pending_q;

	always_comb begin
		pending_d  = pending_q;
		hold_cnt_d = hold_cnt_q;
		if (run) begin
			if (pending_q) begin
				if (!held) begin
					if (keyer_desktop) begin
						pending_d = 1'b0;
					end else if (hold_cnt_q < hold_ticks) begin
						hold_cnt_d = hold_cnt_q + HOLD_W'(1);
					end else begin
						pending_d = 1'b0;
					end
				end
			end else if (has_report) begin
				pending_d  = 1'b1;
				hold_cnt_d = '0;
			end
		end
	end

	always_comb begin
		lane_ctrl.load_cur = fire && report_nz;
		lane_ctrl.load_lat = fire && created;
		status.created     = created;
		status.pending     = pending_d;
		status.held        = held;
		count_next         = has_report ? count : cur_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			hold_cnt_q  <= '0;
			cur_count_q <= '0;
		end else if (fire) begin
			pending_q   <= pending_d;
			hold_cnt_q  <= hold_cnt_d;
			cur_count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (lane_ctrl.load_lat) begin
			lat_count_q <= count;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/trhq_skid.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Result output buffer
// Output register with one skid entry so a beat is taken while one waits.
// ----------------------------------------------------------------------------
module trhq_skid
	import trhq_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push_valid,
	output logic         push_stall,
	input  wire result_t push_data,
	output logic         pop_valid,
	input  wire logic    pop_stall,
	output result_t      pop_data
);

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    push_fire, slot_free;

	assign push_stall = skid_valid_q;
	assign push_fire  = push_valid && !skid_valid_q;
	assign slot_free  = !out_valid_q || !pop_stall;
	assign pop_valid  = out_valid_q;
	assign pop_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q  <= skid_valid_q || push_fire;
			skid_valid_q <= 1'b0;
		end else if (push_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push_fire) begin
				out_q <= push_data;
			end
		end else if (push_fire) begin
			skid_q <= push_data;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/touch_report_hold_qualifier.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Touch report hold qualifier
// Mirrors touch points, tracks the pending touch event and its hold window.
// ----------------------------------------------------------------------------
// One tick beat enters per poll tick on tick_valid/tick_stall and yields one
// result beat on result_valid/result_stall. A beat is taken at a clock edge
// where valid is high and stall is low.
// The result of an accepted tick is registered into the output register or
// the skid entry. Throughput: one tick per cycle while tick_stall is low, set
// by the single register stage behind the lanes; all points are mirrored and
// compared in parallel lanes and one merge stage decides the event.
// When result_stall holds a result, one more tick is still taken into a skid
// entry; tick_stall then rises until the output register drains.
// Reset clears the pending flag, hold counter, point count and points, and
// loads the registers with jitter 5, hold 10 and a screen of 800 by 480.
// Registers are written through cfg_write/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
module touch_report_hold_qualifier
	import trhq_pkg::*;
#(
	parameter int MAX_POINTS = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  tick_valid,
	output logic                       tick_stall,
	input  wire tick_t                 tick,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result
);

	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [THR_W-1:0]  jitter_q;
	logic [HOLD_W-1:0] hold_q;
	logic [DIM_W-1:0]  width_q, height_q;

	logic                   fire;
	logic [CW-1:0]          count_sat, count_next;
	logic [MAX_POINTS-1:0]  moved;
	logic [PT_W-1:0]        lane_x [MAX_POINTS];
	logic [PT_W-1:0]        lane_y [MAX_POINTS];
	lane_ctrl_t             lane_ctrl;
	status_t                status;
	result_t                res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jitter_q <= JITTER_RESET;
			hold_q   <= HOLD_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_e'(cfg_index))
				REG_JITTER: jitter_q <= cfg_data[THR_W-1:0];
				REG_HOLD:   hold_q   <= cfg_data[HOLD_W-1:0];
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign count_sat = (tick.raw_count > CNT_IN_W'(MAX_POINTS)) ? CW'(MAX_POINTS)
		: CW'(tick.raw_count);

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_lane
		logic [RAW_W-1:0] raw_x, raw_y;
		if (i < RAW_LANES) begin : g_raw
			assign raw_x = tick.raw_x_packed[i*RAW_W +: RAW_W];
			assign raw_y = tick.raw_y_packed[i*RAW_W +: RAW_W];
		end else begin : g_zero
			assign raw_x = '0;
			assign raw_y = '0;
		end

		trhq_lane u_lane (
			.clk              (clk),
			.arst_n           (arst_n),
			.raw_x            (raw_x),
			.raw_y            (raw_y),
			.active           (count_sat > CW'(i)),
			.screen_width     (width_q),
			.screen_height    (height_q),
			.jitter_threshold (jitter_q),
			.ctrl             (lane_ctrl),
			.next_x           (lane_x[i]),
			.next_y           (lane_y[i]),
			.moved            (moved[i])
		);
	end

	trhq_ctrl #(
		.N  (MAX_POINTS),
		.CW (CW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.has_report    (tick.has_report),
		.keyer_desktop (tick.keyer_desktop),
		.count         (count_sat),
		.hold_ticks    (hold_q),
		.moved         (moved),
		.lane_ctrl     (lane_ctrl),
		.status        (status),
		.count_next    (count_next)
	);

	always_comb begin
		res_d                 = '0;
		res_d.event_created   = status.created;
		res_d.event_pending   = status.pending;
		res_d.same_spot_hold  = status.held;
		res_d.point_count     = CNT_OUT_W'(count_next);
		for (int k = 0; k < RAW_LANES; k++) begin
			if (k < MAX_POINTS) begin
				res_d.points_x_packed[k*PT_W +: PT_W] = lane_x[k];
				res_d.points_y_packed[k*PT_W +: PT_W] = lane_y[k];
			end
		end
	end

	assign fire = tick_valid && !tick_stall;

	trhq_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (tick_valid),
		.push_stall (tick_stall),
		.push_data  (res_d),
		.pop_valid  (result_valid),
		.pop_stall  (result_stall),
		.pop_data   (result)
	);

`ifndef SYNTHESIS
	a_stall_after_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tick_stall) |-> $past(result_valid && result_stall))
		else $error("tick_stall rose without a held result beat");

	a_created_is_pending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.event_created |->
			result.event_pending && !result.same_spot_hold)
		else $error("created event is not pending or is also held");

	a_held_is_pending: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.same_spot_hold |-> result.event_pending)
		else $error("held event is not pending");
`endif

endmodule
`default_nettype wire

// ----- dv/touch_report_hold_qualifier_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch report hold qualifier testbench
// Drives poll tick beats through the qualifier under random sender bursts and
// receiver stalls. Each accepted tick is run through a local model of the
// mirror, latch and hold logic, and every result beat is compared field by
// field against the oldest predicted result. Register settings are changed
// only while the block is idle, covering the reset values and both extremes.
// ----------------------------------------------------------------------------
module touch_report_hold_qualifier_tb;
	import trhq_pkg::*;

	localparam int MAX_PTS     = 5;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 4;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_e;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  tick_valid   = 1'b0;
	logic                  tick_stall;
	tick_t                 tick         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;

	// Register copies seen by the predictor.
	logic [THR_W-1:0]  cfg_thr    = JITTER_RESET;
	logic [HOLD_W-1:0] cfg_hold   = HOLD_RESET;
	logic [DIM_W-1:0]  cfg_width  = WIDTH_RESET;
	logic [DIM_W-1:0]  cfg_height = HEIGHT_RESET;

	// Predictor state.
	logic                 pend_flag = 1'b0;
	logic [HOLD_W-1:0]    hold_cnt  = '0;
	logic [CNT_OUT_W-1:0] cur_cnt   = '0;
	logic signed [PT_W-1:0] cur_x [RAW_LANES] = '{default: '0};
	logic signed [PT_W-1:0] cur_y [RAW_LANES] = '{default: '0};
	logic [CNT_OUT_W-1:0] lat_cnt   = '0;
	logic signed [PT_W-1:0] lat_x [RAW_LANES] = '{default: '0};
	logic signed [PT_W-1:0] lat_y [RAW_LANES] = '{default: '0};

	result_t predicted_results [$];
	result_t want_beat;
	int      mismatches  = 0;
	int      idle_cycles = 0;

	bit      sending    = 1'b0;
	int      burst_left = 0;

	logic [RAW_W-1:0] base_x [RAW_LANES] = '{default: '0};
	logic [RAW_W-1:0] base_y [RAW_LANES] = '{default: '0};
	int               base_cnt = 1;

	stall_mode_e stall_mode   = STALL_NONE;
	int          stall_cyc    = 0;
	int          stall_len    = 100;
	int          stall_period = 3;

	touch_report_hold_qualifier #(
		.MAX_POINTS(MAX_PTS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.tick        (tick),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #4 clk = ~clk;

	function automatic bit far_apart(input logic signed [PT_W-1:0] a,
			input logic signed [PT_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		if (d < 0) begin
			d = -d;
		end
		return d > int'(cfg_thr);
	endfunction

	function automatic result_t predict_tick(input tick_t t);
		result_t              r;
		logic [CNT_OUT_W-1:0] cnt;
		logic                 run;
		logic                 hold;
		logic                 moved;
		int                   i;
		r   = '0;
		run = 1'b1;
		if (t.has_report) begin
			cnt = (int'(t.raw_count) > MAX_PTS) ? CNT_OUT_W'(MAX_PTS) : t.raw_count[CNT_OUT_W-1:0];
			cur_cnt = cnt;
			if (cnt == 0) begin
				run = 1'b0;
			end else begin
				for (i = 0; i < RAW_LANES; i++) begin
					if (i < int'(cnt)) begin
						cur_x[i] = {1'b0, cfg_width} - {1'b0, t.raw_x_packed[i*RAW_W +: RAW_W]};
						cur_y[i] = {1'b0, cfg_height} - {1'b0, t.raw_y_packed[i*RAW_W +: RAW_W]};
					end else begin
						cur_x[i] = '0;
						cur_y[i] = '0;
					end
				end
			end
		end
		if (run) begin
			if (pend_flag) begin
				hold = 1'b0;
				if (t.has_report && lat_cnt == cur_cnt) begin
					moved = 1'b0;
					for (i = 0; i < int'(cur_cnt); i++) begin
						if (far_apart(lat_x[i], cur_x[i]) || far_apart(lat_y[i], cur_y[i])) begin
							moved = 1'b1;
						end
					end
					hold = !moved;
				end
				if (hold) begin
					r.same_spot_hold = 1'b1;
				end else if (t.keyer_desktop) begin
					pend_flag = 1'b0;
				end else if (hold_cnt < cfg_hold) begin
					hold_cnt = hold_cnt + HOLD_W'(1);
				end else begin
					pend_flag = 1'b0;
				end
			end else if (t.has_report) begin
				lat_cnt   = cur_cnt;
				lat_x     = cur_x;
				lat_y     = cur_y;
				pend_flag = 1'b1;
				hold_cnt  = '0;
				r.event_created = 1'b1;
			end
		end
		r.event_pending = pend_flag;
		r.point_count   = cur_cnt;
		for (i = 0; i < RAW_LANES; i++) begin
			r.points_x_packed[i*PT_W +: PT_W] = cur_x[i];
			r.points_y_packed[i*PT_W +: PT_W] = cur_y[i];
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (result_valid && !result_stall) begin
			if (predicted_results.size() == 0) begin
				$error("result beat with no expected result");
				mismatches++;
			end else begin
				want_beat = predicted_results.pop_front();
				check_field("event_created", want_beat.event_created, result.event_created);
				check_field("event_pending", want_beat.event_pending, result.event_pending);
				check_field("same_spot_hold", want_beat.same_spot_hold, result.same_spot_hold);
				check_field("point_count", want_beat.point_count, result.point_count);
				check_field("points_x_packed", want_beat.points_x_packed, result.points_x_packed);
				check_field("points_y_packed", want_beat.points_y_packed, result.points_y_packed);
			end
		end
		if (tick_valid && !tick_stall) begin
			predicted_results.push_back(predict_tick(tick));
		end
	end

	always @(posedge clk) begin
		stall_cyc++;
		if (stall_cyc >= stall_len) begin
			stall_cyc    = 0;
			stall_len    = $urandom_range(50, 300);
			stall_mode   = stall_mode_e'($urandom_range(0, 3));
			stall_period = $urandom_range(2, 7);
		end
		case (stall_mode)
			STALL_NONE: begin
				result_stall <= 1'b0;
			end
			STALL_LIGHT: begin
				result_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_HEAVY: begin
				result_stall <= ($urandom_range(0, 9) < 6);
			end
			default: begin
				result_stall <= ((stall_cyc % stall_period) == 0);
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_valid && !tick_stall) || (result_valid && !result_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic release_tick();
		if (sending) begin
			tick_valid <= 1'b0;
			sending = 1'b0;
		end
	endtask

	task automatic send_tick(input tick_t t);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				release_tick();
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		tick       <= t;
		tick_valid <= 1'b1;
		sending = 1'b1;
		do @(posedge clk); while (tick_stall);
	endtask

	task automatic wait_results();
		release_tick();
		do @(posedge clk); while (predicted_results.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_JITTER: cfg_thr    = val[THR_W-1:0];
			REG_HOLD:   cfg_hold   = val[HOLD_W-1:0];
			REG_WIDTH:  cfg_width  = val[DIM_W-1:0];
			REG_HEIGHT: cfg_height = val[DIM_W-1:0];
			default: ;
		endcase
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int thr, input int hold, input int w, input int h);
		wait_results();
		write_reg(REG_JITTER, CFG_DATA_W'(thr));
		write_reg(REG_HOLD, CFG_DATA_W'(hold));
		write_reg(REG_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_HEIGHT, CFG_DATA_W'(h));
	endtask

	function automatic logic [RAW_LANES*RAW_W-1:0] lanes5(input int a, input int b,
			input int c, input int d, input int e);
		return {RAW_W'(e), RAW_W'(d), RAW_W'(c), RAW_W'(b), RAW_W'(a)};
	endfunction

	function automatic tick_t mk_tick(input bit has, input int cnt,
			input logic [RAW_LANES*RAW_W-1:0] rx, input logic [RAW_LANES*RAW_W-1:0] ry,
			input bit keyer);
		tick_t t;
		t.has_report    = has;
		t.raw_count     = CNT_IN_W'(cnt);
		t.raw_x_packed  = rx;
		t.raw_y_packed  = ry;
		t.keyer_desktop = keyer;
		return t;
	endfunction

	function automatic logic [RAW_W-1:0] nudge(input logic [RAW_W-1:0] v, input int span);
		int n;
		n = int'(v) + int'($urandom_range(0, 2 * span)) - span;
		if (n < 0) begin
			n = 0;
		end
		if (n > 2047) begin
			n = 2047;
		end
		return RAW_W'(n);
	endfunction

	function automatic tick_t make_random_tick();
		tick_t t;
		int    pick;
		int    span;
		int    i;
		t.has_report    = 1'b1;
		t.keyer_desktop = ($urandom_range(0, 6) == 0);
		t.raw_count     = CNT_IN_W'($urandom_range(0, 15));
		t.raw_x_packed  = (RAW_LANES*RAW_W)'({$urandom, $urandom});
		t.raw_y_packed  = (RAW_LANES*RAW_W)'({$urandom, $urandom});
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			t.has_report = 1'b0;
		end else if (pick < 22) begin
			t.raw_count = '0;
		end else if (pick < 37) begin
			t.raw_count = CNT_IN_W'((pick < 31) ? $urandom_range(1, 5) : $urandom_range(6, 15));
			base_cnt = (int'(t.raw_count) > MAX_PTS) ? MAX_PTS : int'(t.raw_count);
			for (i = 0; i < RAW_LANES; i++) begin
				base_x[i] = t.raw_x_packed[i*RAW_W +: RAW_W];
				base_y[i] = t.raw_y_packed[i*RAW_W +: RAW_W];
			end
		end else begin
			span = ($urandom_range(0, 4) == 0) ? int'(cfg_thr) + 3 : int'(cfg_thr) / 2;
			t.raw_count = CNT_IN_W'(($urandom_range(0, 19) == 0) ? $urandom_range(1, 5) : base_cnt);
			for (i = 0; i < RAW_LANES; i++) begin
				t.raw_x_packed[i*RAW_W +: RAW_W] = nudge(base_x[i], span);
				t.raw_y_packed[i*RAW_W +: RAW_W] = nudge(base_y[i], span);
			end
		end
		return t;
	endfunction

	task automatic test_reset_state();
		send_tick(mk_tick(1'b0, 0, '0, '0, 1'b0));
		send_tick(mk_tick(1'b1, 0, {(RAW_LANES*RAW_W){1'b1}}, '0, 1'b0));
	endtask

	task automatic test_hold_window();
		logic [RAW_LANES*RAW_W-1:0] rx0;
		logic [RAW_LANES*RAW_W-1:0] ry0;
		logic [RAW_LANES*RAW_W-1:0] ones;
		rx0  = lanes5(100, 200, 300, 400, 500);
		ry0  = lanes5(50, 60, 70, 80, 90);
		ones = {(RAW_LANES*RAW_W){1'b1}};
		send_tick(mk_tick(1'b1, 2, rx0, ry0, 1'b0));
		send_tick(mk_tick(1'b1, 2, rx0, ry0, 1'b0));
		send_tick(mk_tick(1'b1, 2, lanes5(105, 200, 300, 400, 500),
			lanes5(45, 60, 70, 80, 90), 1'b0));
		send_tick(mk_tick(1'b1, 2, rx0, lanes5(50, 66, 70, 80, 90), 1'b0));
		send_tick(mk_tick(1'b1, 3, rx0, ry0, 1'b0));
		send_tick(mk_tick(1'b1, 0, ones, ones, 1'b0));
		send_tick(mk_tick(1'b0, 15, ones, ones, 1'b0));
		send_tick(mk_tick(1'b0, 0, '0, '0, 1'b1));
		send_tick(mk_tick(1'b1, 6, ones, ones, 1'b0));
		send_tick(mk_tick(1'b1, 15, '0, '0, 1'b1));
		send_tick(mk_tick(1'b1, 1, lanes5(800, 800, 800, 800, 800),
			lanes5(480, 480, 480, 480, 480), 1'b0));
		repeat (12) send_tick(mk_tick(1'b0, 0, '0, '0, 1'b0));
	endtask

	task automatic test_config_extremes();
		logic [RAW_LANES*RAW_W-1:0] ones;
		ones = {(RAW_LANES*RAW_W){1'b1}};
		set_config(0, 0, 0, 0);
		send_tick(mk_tick(1'b1, 5, ones, ones, 1'b0));
		send_tick(mk_tick(1'b1, 5, ones, ones, 1'b0));
		send_tick(mk_tick(1'b1, 5, lanes5(2047, 2047, 2047, 2047, 2046), ones, 1'b0));
		send_tick(mk_tick(1'b1, 4, ones, ones, 1'b0));
		send_tick(mk_tick(1'b0, 0, '0, '0, 1'b0));
		set_config(255, 15, 2047, 2047);
		send_tick(mk_tick(1'b1, 5, '0, '0, 1'b0));
		send_tick(mk_tick(1'b1, 5, lanes5(255, 0, 0, 0, 255), lanes5(0, 255, 0, 255, 0), 1'b0));
		send_tick(mk_tick(1'b1, 5, lanes5(256, 0, 0, 0, 0), '0, 1'b0));
		repeat (16) send_tick(mk_tick(1'b0, 0, '0, '0, 1'b0));
	endtask

	task automatic test_random_traffic();
		int phase;
		int n;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_config(JITTER_RESET, HOLD_RESET, WIDTH_RESET, HEIGHT_RESET);
				1: set_config(0, 0, 0, 0);
				2: set_config(255, 15, 2047, 2047);
				default: set_config($urandom_range(0, 40), $urandom_range(0, 15),
					$urandom_range(0, 2047), $urandom_range(0, 2047));
			endcase
			for (n = 0; n < 115; n++) begin
				if (n == 57) begin
					wait_results();
				end
				send_tick(make_random_tick());
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_hold_window();
		test_config_extremes();
		test_random_traffic();
		wait_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && predicted_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
